### rtl/assert_macros.svh
// Assertion helpers for the controller core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on each rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/hhk_pkg.sv
`default_nettype none
package hhk_pkg;
    localparam logic [1:0] ACT_EVENT = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_LOST  = 2'd2;

    localparam logic [1:0] SRC_PAD   = 2'd0;
    localparam logic [1:0] SRC_VOL   = 2'd1;
    localparam logic [1:0] SRC_POWER = 2'd2;
    localparam logic [1:0] SRC_LID   = 2'd3;

    localparam logic [15:0] TYPE_SYN = 16'd0;
    localparam logic [15:0] TYPE_KEY = 16'd1;
    localparam logic [15:0] TYPE_SW  = 16'd5;

    localparam logic [15:0] CODE_MENU    = 16'd316;
    localparam logic [15:0] CODE_L1      = 16'd310;
    localparam logic [15:0] CODE_SELECT  = 16'd314;
    localparam logic [15:0] CODE_START   = 16'd315;
    localparam logic [15:0] CODE_VOL_DN  = 16'd114;
    localparam logic [15:0] CODE_VOL_UP  = 16'd115;
    localparam logic [15:0] CODE_POWER   = 16'd116;
    localparam logic [15:0] CODE_DROPPED = 16'd3;
    localparam logic [15:0] CODE_LID     = 16'd0;

    localparam logic [2:0] CMD_VOL_UP  = 3'd0;
    localparam logic [2:0] CMD_VOL_DN  = 3'd1;
    localparam logic [2:0] CMD_SET_BR  = 3'd2;
    localparam logic [2:0] CMD_BR_FAIL = 3'd3;
    localparam logic [2:0] CMD_POWER   = 3'd4;
    localparam logic [2:0] CMD_LID_CL  = 3'd5;
    localparam logic [2:0] CMD_LID_OP  = 3'd6;
    localparam logic [2:0] CMD_EXIT    = 3'd7;

    localparam logic [1:0] CFG_MAX      = 2'd0;
    localparam logic [1:0] CFG_DELAY    = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DN   = 2'd2;

    localparam int DIV_BITS = 24;

    // ceil(2^30 / 100); exact division by 100 for numerators below 2^23.
    localparam logic [23:0] RECIP_100 = 24'd10737419;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  source;
        logic [15:0] event_type;
        logic [15:0] event_code;
        logic [31:0] event_value;
        logic [15:0] panel_level;
    } t_in;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] level_out;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic decode;   // load the item and apply key state
        logic div_pct;  // start the percent division
        logic div_raw;  // start the raw level division
        logic finish;   // build the brightness result
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic emit_now;   // decode produced a result directly
        logic need_br;    // decode asked for a brightness step
        logic div_done;
        logic raw_needed; // the percent step still needs a raw division
    } t_sts;
endpackage
`default_nettype wire

### rtl/hhk_if.sv
`default_nettype none
interface hhk_in_if;
    logic        valid;
    logic        ready;
    hhk_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface hhk_out_if;
    logic         valid;
    logic         ready;
    hhk_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/hhk_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module hhk_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [hhk_pkg::DIV_BITS-1:0] i_num,
    input  wire logic [15:0]                  i_den,
    output logic                              o_done,
    output logic [hhk_pkg::DIV_BITS-1:0]      o_quo
);
    localparam int W = hhk_pkg::DIV_BITS;
    logic [W-1:0] r_quo, n_quo;
    logic [16:0]  r_rem, n_rem;
    logic [4:0]   r_cnt, n_cnt;
    logic         r_busy, n_busy, r_done, n_done;
    logic [16:0]  w_trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[15:0], r_quo[W-1]};
        if (i_start) begin
            n_quo = i_num;
            n_rem = '0;
            n_cnt = 5'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_den}) begin
                n_rem = w_trial - {1'b0, i_den};
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_done = r_done;
    assign o_quo = r_quo;
endmodule
`default_nettype wire

### rtl/hhk_datapath.sv
`default_nettype none
module hhk_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hhk_pkg::t_in  i_item,
    input  wire hhk_pkg::t_cmd i_cmd,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic          i_cfg_we,
    input  wire logic [15:0]   i_cfg_data,
    output hhk_pkg::t_sts      o_sts,
    output hhk_pkg::t_out      o_res
);
    localparam int W = hhk_pkg::DIV_BITS;

    logic [15:0] r_max, r_delay, r_interval;
    logic r_menu, r_l1, r_sel, r_start, r_exit, r_up, r_dn;
    logic [1:0]  r_dir;
    logic [15:0] r_left;
    logic        r_emit, r_need, r_br_up;
    logic [2:0]  r_cmd;
    logic [15:0] r_level;
    logic [15:0] r_lvl_in;
    logic [W-1:0] r_pct;
    logic [22:0] r_rawnum;
    logic        r_raw_done;

    logic [W-1:0] w_num;
    logic         w_start, w_done;
    logic [W-1:0] w_quo;
    logic [15:0]  w_den;
    logic [6:0]   w_tgt;
    logic         w_raw_one;
    logic [46:0]  w_raw_prod;
    logic [16:0]  w_raw;

    hhk_pkg::t_in it;
    assign it = i_item;

    // The divider only serves the percent division by the panel maximum.
    assign w_start = i_cmd.div_pct;
    assign w_den = r_max;
    always_comb begin
        w_raw_one = 1'b0;
        w_tgt = 7'd0;
        if (r_br_up) begin
            if (r_pct < W'(5)) w_tgt = 7'd5;
            else if (r_pct >= W'(95)) w_tgt = 7'd100;
            else w_tgt = 7'(r_pct + W'(5));
        end else if (r_pct <= W'(5)) begin
            w_raw_one = 1'b1;
        end else if (r_pct >= W'(105)) begin
            // A level above the maximum lands on the maximum anyway.
            w_tgt = 7'd100;
        end else begin
            w_tgt = 7'(r_pct - W'(5));
        end
    end
    assign w_num = W'({r_lvl_in, 7'd0}) - W'({r_lvl_in, 5'd0}) + W'({r_lvl_in, 2'd0})
                   + W'(r_max[15:1]);

    // Division by 100 as a reciprocal multiply of the registered numerator.
    assign w_raw_prod = {24'd0, r_rawnum} * {23'd0, hhk_pkg::RECIP_100};
    assign w_raw = w_raw_prod[46:30];

    hhk_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_done), .o_quo(w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 16'd255;
            r_delay <= 16'd300;
            r_interval <= 16'd100;
            {r_menu, r_l1, r_sel, r_start, r_exit, r_up, r_dn} <= '0;
            r_dir <= hhk_pkg::DIR_NONE;
            r_left <= '0;
            r_emit <= 1'b0;
            r_need <= 1'b0;
            r_raw_done <= 1'b0;
        end else begin
            r_raw_done <= i_cmd.div_raw;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hhk_pkg::CFG_MAX: r_max <= i_cfg_data;
                    hhk_pkg::CFG_DELAY: r_delay <= i_cfg_data;
                    hhk_pkg::CFG_INTERVAL: r_interval <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_done && i_cmd.finish == 1'b0 && r_need) r_pct <= w_quo;
            if (i_cmd.finish) begin
                r_cmd <= hhk_pkg::CMD_SET_BR;
                if (w_raw_one || w_raw == '0) r_level <= 16'd1;
                else if (w_raw > {1'b0, r_max}) r_level <= r_max;
                else r_level <= w_raw[15:0];
            end
            if (i_cmd.decode) begin
                logic p, drop;
                p = it.event_value != 32'd0;
                drop = it.event_type == hhk_pkg::TYPE_SYN
                       && it.event_code == hhk_pkg::CODE_DROPPED;
                r_emit <= 1'b0;
                r_need <= 1'b0;
                r_level <= '0;
                r_lvl_in <= it.panel_level;
                if (it.action == hhk_pkg::ACT_TICK) begin
                    if (!((r_dir == hhk_pkg::DIR_UP && r_up)
                          || (r_dir == hhk_pkg::DIR_DN && r_dn))) begin
                        r_dir <= hhk_pkg::DIR_NONE;
                        r_left <= '0;
                    end else if (r_left > 16'd1) begin
                        r_left <= r_left - 16'd1;
                    end else begin
                        r_left <= r_interval;
                        r_emit <= 1'b1;
                        r_cmd <= (r_dir == hhk_pkg::DIR_UP) ? hhk_pkg::CMD_VOL_UP
                                                            : hhk_pkg::CMD_VOL_DN;
                    end
                end else if (it.action == hhk_pkg::ACT_LOST) begin
                    if (it.source == hhk_pkg::SRC_PAD)
                        {r_menu, r_l1, r_sel, r_start, r_exit} <= '0;
                    else if (it.source == hhk_pkg::SRC_VOL) begin
                        {r_up, r_dn} <= '0;
                        r_dir <= hhk_pkg::DIR_NONE;
                        r_left <= '0;
                    end
                end else if (it.action == hhk_pkg::ACT_EVENT) begin
                    unique case (it.source)
                        hhk_pkg::SRC_PAD: begin
                            logic l1, sl, st, hit;
                            l1 = r_l1; sl = r_sel; st = r_start; hit = 1'b1;
                            if (drop) begin
                                {r_menu, r_l1, r_sel, r_start, r_exit} <= '0;
                                hit = 1'b0;
                            end else if (it.event_type != hhk_pkg::TYPE_KEY) hit = 1'b0;
                            else if (it.event_code == hhk_pkg::CODE_MENU) r_menu <= p;
                            else if (it.event_code == hhk_pkg::CODE_L1) l1 = p;
                            else if (it.event_code == hhk_pkg::CODE_SELECT) sl = p;
                            else if (it.event_code == hhk_pkg::CODE_START) st = p;
                            else hit = 1'b0;
                            if (hit) begin
                                r_l1 <= l1; r_sel <= sl; r_start <= st;
                                if (l1 && sl && st) begin
                                    if (!r_exit) begin
                                        r_exit <= 1'b1;
                                        r_emit <= 1'b1;
                                        r_cmd <= hhk_pkg::CMD_EXIT;
                                    end
                                end else r_exit <= 1'b0;
                            end
                        end
                        hhk_pkg::SRC_VOL: begin
                            logic [1:0] d;
                            d = (it.event_code == hhk_pkg::CODE_VOL_UP)
                                ? hhk_pkg::DIR_UP : hhk_pkg::DIR_DN;
                            if (drop) begin
                                {r_up, r_dn} <= '0;
                                r_dir <= hhk_pkg::DIR_NONE;
                                r_left <= '0;
                            end else if (it.event_type == hhk_pkg::TYPE_KEY
                                && (it.event_code == hhk_pkg::CODE_VOL_UP
                                    || it.event_code == hhk_pkg::CODE_VOL_DN)) begin
                                if (d == hhk_pkg::DIR_UP) r_up <= p; else r_dn <= p;
                                if (it.event_value == 32'd1) begin
                                    if (r_menu) begin
                                        r_dir <= hhk_pkg::DIR_NONE;
                                        r_left <= '0;
                                        r_br_up <= d == hhk_pkg::DIR_UP;
                                        if (r_max == 16'd0) begin
                                            r_emit <= 1'b1;
                                            r_cmd <= hhk_pkg::CMD_BR_FAIL;
                                        end else r_need <= 1'b1;
                                    end else begin
                                        r_dir <= d;
                                        r_left <= r_delay;
                                        r_emit <= 1'b1;
                                        r_cmd <= (d == hhk_pkg::DIR_UP) ? hhk_pkg::CMD_VOL_UP
                                                                        : hhk_pkg::CMD_VOL_DN;
                                    end
                                end else if (!p && r_dir == d) begin
                                    r_dir <= hhk_pkg::DIR_NONE;
                                    r_left <= '0;
                                end
                            end
                        end
                        hhk_pkg::SRC_POWER: begin
                            if (it.event_type == hhk_pkg::TYPE_KEY
                                && it.event_code == hhk_pkg::CODE_POWER
                                && it.event_value == 32'd1) begin
                                r_emit <= 1'b1;
                                r_cmd <= hhk_pkg::CMD_POWER;
                            end
                        end
                        hhk_pkg::SRC_LID: begin
                            if (it.event_type == hhk_pkg::TYPE_SW
                                && it.event_code == hhk_pkg::CODE_LID) begin
                                if (it.event_value == 32'd1) begin
                                    r_emit <= 1'b1;
                                    r_cmd <= hhk_pkg::CMD_LID_CL;
                                end else if (it.event_value == 32'd0) begin
                                    r_emit <= 1'b1;
                                    r_cmd <= hhk_pkg::CMD_LID_OP;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end else if (i_cmd.div_raw) begin
                r_need <= 1'b0;
                r_rawnum <= ({16'd0, w_tgt} * {7'd0, r_max}) + 23'd50;
            end
        end
    end

    assign o_sts.emit_now = r_emit;
    assign o_sts.need_br = r_need;
    assign o_sts.div_done = w_done | r_raw_done;
    assign o_sts.raw_needed = ~w_raw_one;
    assign o_res.command = r_cmd;
    assign o_res.level_out = r_level;
endmodule
`default_nettype wire

### rtl/hhk_ctrl.sv
`default_nettype none
module hhk_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire hhk_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output hhk_pkg::t_cmd      o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_PCT  = 3'd2;
    localparam logic [2:0] S_RAW  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_wait, n_wait;

    always_comb begin
        n_state = r_state;
        n_wait = r_wait;
        o_cmd = '0;
        o_in_ready = r_state == S_IDLE;
        o_out_valid = r_state == S_OUT;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.decode = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.emit_now) n_state = S_OUT;
                else if (i_sts.need_br) begin
                    o_cmd.div_pct = 1'b1;
                    n_wait = 1'b0;
                    n_state = S_PCT;
                end else n_state = S_IDLE;
            end
            S_PCT: if (i_sts.div_done) n_state = S_RAW;
            S_RAW: begin
                if (!r_wait) begin
                    if (i_sts.raw_needed) begin
                        o_cmd.div_raw = 1'b1;
                        n_wait = 1'b1;
                    end else n_state = S_FIN;
                end else if (i_sts.div_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait <= n_wait;
        end
    end
endmodule
`default_nettype wire

### rtl/handheld_hotkey_controller_core.sv
`default_nettype none
// Channel | Role | Payload
// in      | sink   | action, source, event_type, event_code, event_value, panel_level
// out     | source | command, level_out
// cfg     | write  | max_level, repeat_delay_ticks, repeat_interval_ticks
// An item without brightness work is decoded, then sends its result if it has one.
// A brightness step runs a 24-step percent division, then a reciprocal multiply
// for the divide by 100 (skipped when a down step bottoms out at raw 1).
// Reset is synchronous and active low; data registers such as r_level are not reset.
// A waiting result holds the input off until the output takes it.
module handheld_hotkey_controller_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    hhk_in_if.sink           i_in,
    hhk_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
`include "assert_macros.svh"
    hhk_pkg::t_cmd w_cmd;
    hhk_pkg::t_sts w_sts;
    hhk_pkg::t_out w_res;

    hhk_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in.valid),
        .i_out_ready(o_out.ready), .i_sts(w_sts), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .o_cmd(w_cmd)
    );

    hhk_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in.payload), .i_cmd(w_cmd),
        .i_cfg_idx(i_cfg_idx), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .o_sts(w_sts), .o_res(w_res)
    );

    assign o_out.payload = w_res;

    `ASSERT_IMPL(a_no_accept_while_out, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    `ASSERT_NEXT(a_decode_leaves_idle, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    `ASSERT_IMPL(a_level_only_bright, i_clk, i_rst_n, o_out.valid && o_out.payload.command != hhk_pkg::CMD_SET_BR, o_out.payload.level_out == 16'd0)
endmodule
`default_nettype wire
